>>> rtl/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg
// Shared types and constants of the complex integer ALU.
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int RESULT_BITS = 33;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_e;

  typedef struct packed {
    logic  valid;
    mode_e mode;
    logic  neg_re;
    logic  neg_im;
    logic  zero_den;
  } ctrl_t;

endpackage

>>> rtl/cia_front.sv
// ----------------------------------------------------------------------------
// cia_front
// Two register stages: partial products, then sums, numerators and divisor.
// ----------------------------------------------------------------------------
module cia_front #(
  parameter int W = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [1:0]                          mode_i,
  input  logic signed [W-1:0]                 ar_i,
  input  logic signed [W-1:0]                 ai_i,
  input  logic signed [W-1:0]                 br_i,
  input  logic signed [W-1:0]                 bi_i,
  output cia_pkg::ctrl_t                      ctrl_o,
  output logic [2*W-1:0]                      den_o,
  output logic [2*W-1:0]                      num_re_o,
  output logic [2*W-1:0]                      num_im_o,
  output logic [cia_pkg::RESULT_BITS-1:0]     res_re_o,
  output logic [cia_pkg::RESULT_BITS-1:0]     res_im_o
);
  import cia_pkg::*;

  localparam int PW = 2 * W;
  localparam int EW = (PW + 2 > RESULT_BITS) ? PW + 2 : RESULT_BITS;

  logic               va_q;
  mode_e              mode_a_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, s_r_q, s_i_q;
  logic signed [PW-1:0] p_rr_d, p_ii_d, p_ri_d, p_ir_d, s_r_d, s_i_d;
  logic signed [W:0]  as_re_q, as_im_q, as_re_d, as_im_d;

  logic signed [PW:0] mul_re, mul_im, n_re, n_im;
  logic [PW-1:0]      den_d;
  logic signed [EW-1:0] ext_re, ext_im;
  ctrl_t              ctrl_d, ctrl_q;
  logic [PW-1:0]      num_re_d, num_im_d, den_q, num_re_q, num_im_q;
  logic [RESULT_BITS-1:0] res_re_d, res_im_d, res_re_q, res_im_q;

  always_comb begin
    p_rr_d = ar_i * br_i;
    p_ii_d = ai_i * bi_i;
    p_ri_d = ar_i * bi_i;
    p_ir_d = ai_i * br_i;
    s_r_d  = br_i * br_i;
    s_i_d  = bi_i * bi_i;
    if (mode_e'(mode_i) == MODE_SUB) begin
      as_re_d = (W+1)'(ar_i) - (W+1)'(br_i);
      as_im_d = (W+1)'(ai_i) - (W+1)'(bi_i);
    end else begin
      as_re_d = (W+1)'(ar_i) + (W+1)'(br_i);
      as_im_d = (W+1)'(ai_i) + (W+1)'(bi_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q     <= 1'b0;
      mode_a_q <= MODE_ADD;
    end else if (en_i) begin
      va_q     <= valid_i;
      mode_a_q <= mode_e'(mode_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_rr_q  <= p_rr_d;
      p_ii_q  <= p_ii_d;
      p_ri_q  <= p_ri_d;
      p_ir_q  <= p_ir_d;
      s_r_q   <= s_r_d;
      s_i_q   <= s_i_d;
      as_re_q <= as_re_d;
      as_im_q <= as_im_d;
    end
  end

  always_comb begin
    mul_re = (PW+1)'(p_rr_q) - (PW+1)'(p_ii_q);
    mul_im = (PW+1)'(p_ri_q) + (PW+1)'(p_ir_q);
    n_re   = (PW+1)'(p_rr_q) + (PW+1)'(p_ii_q);
    n_im   = (PW+1)'(p_ir_q) - (PW+1)'(p_ri_q);
    den_d  = $unsigned(s_r_q) + $unsigned(s_i_q);
    if (mode_a_q == MODE_MUL) begin
      ext_re = EW'(mul_re);
      ext_im = EW'(mul_im);
    end else begin
      ext_re = EW'(as_re_q);
      ext_im = EW'(as_im_q);
    end
    res_re_d = ext_re[RESULT_BITS-1:0];
    res_im_d = ext_im[RESULT_BITS-1:0];
    num_re_d = n_re[PW] ? PW'(-n_re) : n_re[PW-1:0];
    num_im_d = n_im[PW] ? PW'(-n_im) : n_im[PW-1:0];
    ctrl_d.valid    = va_q;
    ctrl_d.mode     = mode_a_q;
    ctrl_d.neg_re   = n_re[PW];
    ctrl_d.neg_im   = n_im[PW];
    ctrl_d.zero_den = (den_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q    <= den_d;
      num_re_q <= num_re_d;
      num_im_q <= num_im_d;
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
    end
  end

  assign ctrl_o   = ctrl_q;
  assign den_o    = den_q;
  assign num_re_o = num_re_q;
  assign num_im_o = num_im_q;
  assign res_re_o = res_re_q;
  assign res_im_o = res_im_q;

endmodule

>>> rtl/cia_div_stage.sv
// ----------------------------------------------------------------------------
// cia_div_stage
// One restoring divider step for both quotient parts, registered.
// ----------------------------------------------------------------------------
module cia_div_stage #(
  parameter int DW = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  cia_pkg::ctrl_t                  ctrl_i,
  input  logic [DW-1:0]                   den_i,
  input  logic [DW-1:0]                   rem_re_i,
  input  logic [DW-1:0]                   num_re_i,
  input  logic [DW-1:0]                   rem_im_i,
  input  logic [DW-1:0]                   num_im_i,
  input  logic [cia_pkg::RESULT_BITS-1:0] res_re_i,
  input  logic [cia_pkg::RESULT_BITS-1:0] res_im_i,
  output cia_pkg::ctrl_t                  ctrl_o,
  output logic [DW-1:0]                   den_o,
  output logic [DW-1:0]                   rem_re_o,
  output logic [DW-1:0]                   num_re_o,
  output logic [DW-1:0]                   rem_im_o,
  output logic [DW-1:0]                   num_im_o,
  output logic [cia_pkg::RESULT_BITS-1:0] res_re_o,
  output logic [cia_pkg::RESULT_BITS-1:0] res_im_o
);
  import cia_pkg::*;

  logic [DW:0]   sh_re, sh_im, df_re, df_im;
  logic [DW-1:0] rem_re_d, rem_im_d, num_re_d, num_im_d;
  ctrl_t         ctrl_q;
  logic [DW-1:0] den_q, rem_re_q, rem_im_q, num_re_q, num_im_q;
  logic [RESULT_BITS-1:0] res_re_q, res_im_q;

  always_comb begin
    sh_re = {rem_re_i, num_re_i[DW-1]};
    sh_im = {rem_im_i, num_im_i[DW-1]};
    df_re = sh_re - {1'b0, den_i};
    df_im = sh_im - {1'b0, den_i};
    rem_re_d = df_re[DW] ? sh_re[DW-1:0] : df_re[DW-1:0];
    rem_im_d = df_im[DW] ? sh_im[DW-1:0] : df_im[DW-1:0];
    num_re_d = {num_re_i[DW-2:0], ~df_re[DW]};
    num_im_d = {num_im_i[DW-2:0], ~df_im[DW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q    <= den_i;
      rem_re_q <= rem_re_d;
      rem_im_q <= rem_im_d;
      num_re_q <= num_re_d;
      num_im_q <= num_im_d;
      res_re_q <= res_re_i;
      res_im_q <= res_im_i;
    end
  end

  assign ctrl_o   = ctrl_q;
  assign den_o    = den_q;
  assign rem_re_o = rem_re_q;
  assign rem_im_o = rem_im_q;
  assign num_re_o = num_re_q;
  assign num_im_o = num_im_q;
  assign res_re_o = res_re_q;
  assign res_im_o = res_im_q;

endmodule

>>> rtl/complex_integer_alu.sv
// Complex integer ALU: one word in and one word out per cycle while the
// output is not stalled. Two front stages form the products and sums, one
// restoring divider stage per quotient bit follows (2*OPERAND_BITS stages,
// real and imaginary side by side), and an output register applies signs and
// the zero-divisor case. A stall on the output holds the whole pipeline.
// ----------------------------------------------------------------------------
// complex_integer_alu
// Add, subtract, multiply or divide two signed complex integers.
// ----------------------------------------------------------------------------
module complex_integer_alu #(
  parameter int OPERAND_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic [1:0]                             mode_i,
  input  logic signed [OPERAND_BITS-1:0]         first_real_i,
  input  logic signed [OPERAND_BITS-1:0]         first_imag_i,
  input  logic signed [OPERAND_BITS-1:0]         second_real_i,
  input  logic signed [OPERAND_BITS-1:0]         second_imag_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic signed [cia_pkg::RESULT_BITS-1:0] result_real_o,
  output logic signed [cia_pkg::RESULT_BITS-1:0] result_imag_o,
  output logic                                   divide_by_zero_o
);
  import cia_pkg::*;

  localparam int DW = 2 * OPERAND_BITS;
  localparam int EW = (DW + 2 > RESULT_BITS) ? DW + 2 : RESULT_BITS;

  logic en;
  ctrl_t ctrl [0:DW];
  logic [DW-1:0] den [0:DW];
  logic [DW-1:0] rem_re [0:DW];
  logic [DW-1:0] rem_im [0:DW];
  logic [DW-1:0] num_re [0:DW];
  logic [DW-1:0] num_im [0:DW];
  logic [RESULT_BITS-1:0] res_re [0:DW];
  logic [RESULT_BITS-1:0] res_im [0:DW];

  logic valid_q;
  logic [RESULT_BITS-1:0] out_re_d, out_im_d, out_re_q, out_im_q;
  logic flag_d, flag_q;
  logic signed [DW:0] q_re, q_im;
  logic signed [EW-1:0] qx_re, qx_im;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  cia_front #(.W(OPERAND_BITS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (valid_i),
    .mode_i   (mode_i),
    .ar_i     (first_real_i),
    .ai_i     (first_imag_i),
    .br_i     (second_real_i),
    .bi_i     (second_imag_i),
    .ctrl_o   (ctrl[0]),
    .den_o    (den[0]),
    .num_re_o (num_re[0]),
    .num_im_o (num_im[0]),
    .res_re_o (res_re[0]),
    .res_im_o (res_im[0])
  );

  assign rem_re[0] = '0;
  assign rem_im[0] = '0;

  for (genvar i = 0; i < DW; i++) begin : g_div
    cia_div_stage #(.DW(DW)) u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .ctrl_i   (ctrl[i]),
      .den_i    (den[i]),
      .rem_re_i (rem_re[i]),
      .num_re_i (num_re[i]),
      .rem_im_i (rem_im[i]),
      .num_im_i (num_im[i]),
      .res_re_i (res_re[i]),
      .res_im_i (res_im[i]),
      .ctrl_o   (ctrl[i+1]),
      .den_o    (den[i+1]),
      .rem_re_o (rem_re[i+1]),
      .num_re_o (num_re[i+1]),
      .rem_im_o (rem_im[i+1]),
      .num_im_o (num_im[i+1]),
      .res_re_o (res_re[i+1]),
      .res_im_o (res_im[i+1])
    );
  end

  always_comb begin
    q_re  = ctrl[DW].neg_re ? -$signed({1'b0, num_re[DW]}) : $signed({1'b0, num_re[DW]});
    q_im  = ctrl[DW].neg_im ? -$signed({1'b0, num_im[DW]}) : $signed({1'b0, num_im[DW]});
    qx_re = EW'(q_re);
    qx_im = EW'(q_im);
    flag_d   = 1'b0;
    out_re_d = res_re[DW];
    out_im_d = res_im[DW];
    if (ctrl[DW].mode == MODE_DIV) begin
      if (ctrl[DW].zero_den) begin
        flag_d   = 1'b1;
        out_re_d = '0;
        out_im_d = '0;
      end else begin
        out_re_d = qx_re[RESULT_BITS-1:0];
        out_im_d = qx_im[RESULT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= ctrl[DW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_re_q <= out_re_d;
      out_im_q <= out_im_d;
      flag_q   <= flag_d;
    end
  end

  assign valid_o          = valid_q;
  assign result_real_o    = out_re_q;
  assign result_imag_o    = out_im_q;
  assign divide_by_zero_o = flag_q;

`ifndef SYNTHESIS
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && divide_by_zero_o |-> result_real_o == '0 && result_imag_o == '0)
    else $error("divide-by-zero word carries a nonzero result");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |=> $stable(ctrl[0]) && $stable(num_re[0]) && $stable(den[0]))
    else $error("pipeline advanced during output stall");

  a_flag_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && ctrl[DW].valid && ctrl[DW].mode != MODE_DIV |=> !divide_by_zero_o)
    else $error("divide-by-zero flag outside divide mode");
`endif

endmodule
